>>> rtl/crs_pkg.sv
// Shared types, constants and helper functions for the clip rectangle stack.
// Used by crs_cell, crs_calc and clip_rect_stack; depends on nothing else.
`default_nettype none

package crs_pkg;

    // Default number of stack levels, the base entry included.
    localparam int STACK_DEPTH_DEF = 16;

    // Width of the internal coordinate arithmetic (16-bit inputs plus headroom).
    localparam int CW = 19;

    // Reset values of the display size registers.
    localparam logic [14:0] DISP_W_RST = 15'd640;
    localparam logic [14:0] DISP_H_RST = 15'd480;

    // Saturation bounds for stored values.
    localparam logic signed [CW-1:0] SAT_MAX = 19'sd32767;
    localparam logic signed [CW-1:0] SAT_MIN = -19'sd32768;

    // Action codes of an input transaction.
    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    // Configuration register indexes.
    typedef enum logic {
        CFG_DISPLAY_WIDTH  = 1'b0,
        CFG_DISPLAY_HEIGHT = 1'b1
    } t_cfg_reg;

    // Control sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    // One stack entry: clip rectangle and origin offset.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } t_entry;

    // Shift control for the row of stack cells.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

    // Sign-extend a 16-bit value to the internal width.
    function automatic logic signed [CW-1:0] sext16(input logic signed [15:0] v);
        sext16 = CW'(v);
    endfunction

    // Zero-extend a 15-bit display size to the internal width.
    function automatic logic signed [CW-1:0] zext15(input logic [14:0] v);
        zext15 = $signed({{(CW-15){1'b0}}, v});
    endfunction

    // Saturate an internal value to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
        logic signed [15:0] r;
        if (v > SAT_MAX) begin
            r = 16'sh7fff;
        end else if (v < SAT_MIN) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        sat16 = r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/crs_cell.sv
// One cell of the stack row: holds one pushed entry and shifts with its neighbors.
// Depends on crs_pkg for the entry and shift control types.
`default_nettype none

module crs_cell
    import crs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire t_shift i_ctl,
    input  wire t_entry i_from_up,
    input  wire t_entry i_from_down,
    output t_entry      o_entry
);

    t_entry r_entry;

    // A push moves entries away from the top, a pop moves them toward it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_entry <= i_from_up;
        end else if (i_ctl.pop) begin
            r_entry <= i_from_down;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> rtl/crs_calc.sv
// Push arithmetic: offsets a rectangle by its parent and clips it to the parent.
// Two steps with a register between them; depends on crs_pkg.
`default_nettype none

module crs_calc
    import crs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic signed [15:0] i_rect_x,
    input  wire logic signed [15:0] i_rect_y,
    input  wire logic signed [15:0] i_rect_width,
    input  wire logic signed [15:0] i_rect_height,
    input  wire t_entry             i_parent,
    input  wire logic               i_base,
    input  wire logic [14:0]        i_disp_w,
    input  wire logic [14:0]        i_disp_h,
    output t_entry                  o_entry
);

    logic signed [CW-1:0] px, py, pw, ph;
    logic signed [CW-1:0] sum_w, sum_h;
    logic signed [CW-1:0] n_nx, n_ny, n_nw, n_nh, n_ex, n_ey;
    logic signed [15:0]   n_tx, n_ty;
    logic signed [CW-1:0] r_nx, r_ny, r_nw, r_nh, r_ex, r_ey;
    logic signed [15:0]   r_tx, r_ty;
    logic signed [CW-1:0] b_nx, b_ny, b_dx, b_dy, b_nw, b_nh;

    // First step: move the corner by the parent and trim any left or top overshoot.
    // The corner lies before the parent's exactly when the relative offset is negative.
    always_comb begin
        px    = sext16(i_parent.x);
        py    = sext16(i_parent.y);
        pw    = i_base ? zext15(i_disp_w) : sext16(i_parent.w);
        ph    = i_base ? zext15(i_disp_h) : sext16(i_parent.h);
        sum_w = sext16(i_rect_width) + sext16(i_rect_x);
        sum_h = sext16(i_rect_height) + sext16(i_rect_y);
        n_ex  = px + pw;
        n_ey  = py + ph;
        if (i_rect_x[15]) begin
            n_nx = px;
            n_tx = i_rect_x;
            n_nw = sum_w[CW-1] ? '0 : sum_w;
        end else begin
            n_nx = px + sext16(i_rect_x);
            n_tx = i_parent.ox;
            n_nw = sext16(i_rect_width);
        end
        if (i_rect_y[15]) begin
            n_ny = py;
            n_ty = i_rect_y;
            n_nh = sum_h[CW-1] ? '0 : sum_h;
        end else begin
            n_ny = py + sext16(i_rect_y);
            n_ty = i_parent.oy;
            n_nh = sext16(i_rect_height);
        end
    end

    // Intermediate register between the two steps.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_nx <= n_nx;
            r_ny <= n_ny;
            r_nw <= n_nw;
            r_nh <= n_nh;
            r_ex <= n_ex;
            r_ey <= n_ey;
            r_tx <= n_tx;
            r_ty <= n_ty;
        end
    end

    // Second step: clamp the corner to the far edge, then clip the far edge.
    always_comb begin
        b_nx = (r_nx > r_ex) ? r_ex : r_nx;
        b_ny = (r_ny > r_ey) ? r_ey : r_ny;
        b_dx = r_ex - b_nx;
        b_dy = r_ey - b_ny;
        b_nw = (r_nw > b_dx) ? b_dx : r_nw;
        b_nh = (r_nh > b_dy) ? b_dy : r_nh;
    end

    // Stored values saturate to 16 bits.
    assign o_entry.x  = sat16(b_nx);
    assign o_entry.y  = sat16(b_ny);
    assign o_entry.w  = sat16(b_nw);
    assign o_entry.h  = sat16(b_nh);
    assign o_entry.ox = r_tx;
    assign o_entry.oy = r_ty;

endmodule

`default_nettype wire

>>> rtl/clip_rect_stack.sv
// Clip rectangle stack. An accepted transaction passes through the crs_calc register and
// the apply state into the output register; no new transaction is taken until it is applied.
// The result sits in an output register, so the next transaction is taken while it waits.
// Reset empties the stack to the zero base entry, sets the display size to 640 by 480
// and clears the output valid flag. Depends on crs_pkg, crs_calc and crs_cell.
`default_nettype none

module clip_rect_stack
    import crs_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [14:0]        i_cfg_data,
    // input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [15:0] i_rect_x,
    input  wire logic signed [15:0] i_rect_y,
    input  wire logic signed [15:0] i_rect_width,
    input  wire logic signed [15:0] i_rect_height,
    // output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [15:0]      o_clip_x,
    output logic signed [15:0]      o_clip_y,
    output logic signed [15:0]      o_clip_width,
    output logic signed [15:0]      o_clip_height,
    output logic signed [15:0]      o_origin_x,
    output logic signed [15:0]      o_origin_y,
    output logic [3:0]              o_depth,
    output logic                    o_overflow
);

    localparam int NCELL   = STACK_DEPTH - 1;
    localparam int DW      = $clog2(STACK_DEPTH);
    localparam int POP_IDX = (NCELL > 1) ? 1 : 0;

    t_state         r_state, n_state;
    logic [14:0]    r_disp_w, r_disp_h;
    t_action        r_act;
    logic [DW-1:0]  r_depth, n_depth;
    t_entry         r_out, n_top;
    logic [DW-1:0]  r_out_depth;
    logic           r_out_ovf;
    logic           r_out_valid;
    t_entry         cell_q [NCELL];
    t_entry         parent, new_entry;
    t_shift         shift;
    logic           in_fire, out_free, apply_fire;
    logic           push_ok, do_push, do_pop, ovf;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp_w <= DISP_W_RST;
            r_disp_h <= DISP_H_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_DISPLAY_WIDTH:  r_disp_w <= i_cfg_data;
                CFG_DISPLAY_HEIGHT: r_disp_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake qualifiers.
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Parent of a push is the top entry; the base entry is all zero.
    assign parent = (r_depth != '0) ? cell_q[0] : '0;

    crs_calc u_calc (
        .i_clk         (i_clk),
        .i_load        (in_fire),
        .i_rect_x      (i_rect_x),
        .i_rect_y      (i_rect_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_parent      (parent),
        .i_base        (r_depth == '0),
        .i_disp_w      (r_disp_w),
        .i_disp_h      (r_disp_h),
        .o_entry       (new_entry)
    );

    // Action register, captured with the transaction.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_act <= t_action'(i_action);
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, action decode, new depth and new top entry.
    always_comb begin
        n_state    = r_state;
        apply_fire = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (out_free) begin
                    apply_fire = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        push_ok = (r_depth < DW'(NCELL));
        do_push = 1'b0;
        do_pop  = 1'b0;
        ovf     = 1'b0;
        n_depth = r_depth;
        n_top   = (r_depth != '0) ? cell_q[0] : '0;
        case (r_act)
            ACT_PUSH: begin
                if (push_ok) begin
                    do_push = 1'b1;
                    n_depth = r_depth + 1'b1;
                    n_top   = new_entry;
                end else begin
                    ovf = 1'b1;
                end
            end
            ACT_POP: begin
                if (r_depth != '0) begin
                    do_pop  = 1'b1;
                    n_depth = r_depth - 1'b1;
                    n_top   = (r_depth > DW'(1)) ? cell_q[POP_IDX] : '0;
                end
            end
            ACT_CLEAR: begin
                n_depth = '0;
                n_top   = '0;
            end
            default: ;
        endcase

        shift.push = apply_fire && do_push;
        shift.pop  = apply_fire && do_pop;
    end

    // Row of stack cells; cell 0 holds the top pushed entry.
    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        t_entry from_up, from_down;
        if (i == 0) begin : g_first
            assign from_up = new_entry;
        end else begin : g_mid
            assign from_up = cell_q[i-1];
        end
        if (i == NCELL - 1) begin : g_last
            assign from_down = cell_q[i];
        end else begin : g_inner
            assign from_down = cell_q[i+1];
        end
        crs_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (shift),
            .i_from_up   (from_up),
            .i_from_down (from_down),
            .o_entry     (cell_q[i])
        );
    end

    // Depth counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (apply_fire) begin
            r_depth <= n_depth;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (apply_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_fire) begin
            r_out       <= n_top;
            r_out_depth <= n_depth;
            r_out_ovf   <= ovf;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_clip_x      = r_out.x;
    assign o_clip_y      = r_out.y;
    assign o_clip_width  = r_out.w;
    assign o_clip_height = r_out.h;
    assign o_origin_x    = r_out.ox;
    assign o_origin_y    = r_out.oy;
    assign o_depth       = 4'(r_out_depth);
    assign o_overflow    = r_out_ovf;

`ifndef NO_ASSERTIONS
    // The depth never passes the number of cells.
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(NCELL))
        else $error("stack depth beyond cell count");

    // An empty stack reports the zero base entry.
    a_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_depth == '0) |-> (r_out == '0))
        else $error("base entry reported nonzero");

    // Overflow is only reported with a full stack.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ovf) |-> (r_out_depth == DW'(NCELL)))
        else $error("overflow with stack not full");

    // Finishing a transaction always presents a result next cycle.
    a_apply_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_fire |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result missing after apply");
`endif

endmodule

`default_nettype wire
